>>> rtl/lagged_mrg_random_generator_assert.svh
// assertion macros for the lagged mrg random generator
// no dependencies; included by the top level, empty when SYNTH is defined
`ifndef LAGGED_MRG_RANDOM_GENERATOR_ASSERT_SVH
`define LAGGED_MRG_RANDOM_GENERATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LMRG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmrg assertion failed");
// next-cycle implication
`define LMRG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmrg assertion failed");
`else
`define LMRG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LMRG_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/lmrg_pkg.sv
// shared types and constants of the lagged mrg random generator
// no dependencies
package lmrg_pkg;

   localparam int KIND_W = 2;
   localparam int WORD_W = 31;
   localparam int MULT_W = 26;
   localparam int PROD_W = WORD_W + MULT_W;

   // modulus 2^31-1 and multiplier magnitude 2^25+2^7 (multiplier is its negative)
   localparam logic [WORD_W-1:0] MOD_VAL  = 31'h7FFF_FFFF;
   localparam logic [MULT_W-1:0] MULT_MAG = 26'h200_0080;

   // request kinds; the fourth code is ignored
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_DRAW   = 2'd1,
      KIND_SETPOS = 2'd2
   } kind_type;

endpackage

>>> rtl/lagged_mrg_random_generator.sv
// DX-1597-2-7 lagged multiple recursive generator, top level
// depends on lmrg_pkg and lagged_mrg_random_generator_assert.svh
`include "lagged_mrg_random_generator_assert.svh"

// The block holds a ring of LONG_LAG 31-bit words in one memory (one write
// port, two registered read ports) and a current position. A draw beat reads
// the word at the position and the word SHORT_LAG slots before it, returns
// x = -(2^25+2^7)*(older+newer) mod 2^31-1, writes x back at the position and
// steps the position. Load beats write one seed word or set the position and
// return nothing; slots at or beyond LONG_LAG are ignored, as is kind 3.
// An item passes through five register stages (memory read, sum fold,
// multiply, two fold stages), and a draw result then enters the output
// register. One beat is taken per cycle unless a stalled output keeps a draw
// in the last stage and so backs up the stages. A draw is also held off
// while an item in the five stages still has to write a slot the draw reads;
// with SHORT_LAG of 6 or more a run of draws with no position change streams
// at one per cycle, with SHORT_LAG below 6 a draw waits for the write of the
// draw SHORT_LAG back. Words must be loaded before they are drawn from; there
// is no clearing pass after reset.
module lagged_mrg_random_generator #(
   parameter int LONG_LAG  = 1597,
   parameter int SHORT_LAG = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lmrg_pkg::KIND_W-1:0]    req_kind,
   input  logic [$clog2(LONG_LAG)-1:0]    req_word_index,
   input  logic [lmrg_pkg::WORD_W-1:0]    req_word_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lmrg_pkg::WORD_W-1:0]    rsp_random_value
);
   import lmrg_pkg::*;

   localparam int POS_W = $clog2(LONG_LAG);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(LONG_LAG - 1);
   localparam logic [POS_W-1:0] SHORT_C  = POS_W'(SHORT_LAG);
   localparam logic [POS_W-1:0] LAG_DIFF = POS_W'(LONG_LAG - SHORT_LAG);

   // ring memory and its registered read data
   logic [WORD_W-1:0] ring_mem [LONG_LAG];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] back_addr;

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, s5_valid_in;
   logic s1_free, s2_free, s3_free, s4_free, s5_free;
   logic s5_go, out_free;
   logic s1_load_ff, s2_load_ff, s3_load_ff, s4_load_ff, s5_load_ff;
   logic [POS_W-1:0] s1_addr_ff, s2_addr_ff, s3_addr_ff, s4_addr_ff, s5_addr_ff;

   // stage data; load beats carry their seed word in the same field
   logic [WORD_W-1:0] s1_value_ff;
   logic [WORD_W-1:0] s2_data_ff;
   logic [PROD_W-1:0] s3_data_ff;
   logic [WORD_W:0]   s4_data_ff;
   logic [WORD_W-1:0] s5_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff;

   logic              req_fire, req_is_draw, idx_ok, enter, hazard;
   logic [WORD_W:0]   sum_raw, sum_fold, fold2;
   logic [WORD_W-1:0] sum_mod, prod_mod, draw_x, wr_data;

   // request decode
   assign req_is_draw = (req_kind == KIND_DRAW);
   assign idx_ok      = ({1'b0, req_word_index} <= {1'b0, LAST_POS});
   assign back_addr   = (pos_ff >= SHORT_C) ? pos_ff - SHORT_C : pos_ff + LAG_DIFF;

   // a draw waits while any stage still owes a write to a slot it reads
   always_comb begin
      hazard = 1'b0;
      if (s1_valid_ff && (s1_addr_ff == pos_ff || s1_addr_ff == back_addr)) hazard = 1'b1;
      if (s2_valid_ff && (s2_addr_ff == pos_ff || s2_addr_ff == back_addr)) hazard = 1'b1;
      if (s3_valid_ff && (s3_addr_ff == pos_ff || s3_addr_ff == back_addr)) hazard = 1'b1;
      if (s4_valid_ff && (s4_addr_ff == pos_ff || s4_addr_ff == back_addr)) hazard = 1'b1;
      if (s5_valid_ff && (s5_addr_ff == pos_ff || s5_addr_ff == back_addr)) hazard = 1'b1;
   end

   // stage hand-off chain, from the output register back
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s5_go     = s5_valid_ff && (s5_load_ff || out_free);
   assign s5_free   = !s5_valid_ff || s5_go;
   assign s4_free   = !s4_valid_ff || s5_free;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free || (req_is_draw && hazard);
   assign req_fire  = req_valid && !req_stall;

   // which beats enter the pipeline, and position update
   always_comb begin
      enter  = 1'b0;
      pos_in = pos_ff;
      if (req_fire) begin
         case (req_kind)
            KIND_LOAD: begin
               enter = idx_ok;
            end
            KIND_DRAW: begin
               enter  = 1'b1;
               pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);
            end
            KIND_SETPOS: begin
               if (idx_ok) pos_in = req_word_index;
            end
            default: begin
               enter = 1'b0;
            end
         endcase
      end
   end

   // valid bits advance where the next stage has room
   always_comb begin
      s1_valid_in  = s1_free ? enter : s1_valid_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = s3_free ? s2_valid_ff : s3_valid_ff;
      s4_valid_in  = s4_free ? s3_valid_ff : s4_valid_ff;
      s5_valid_in  = s5_free ? s4_valid_ff : s5_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s5_go && !s5_load_ff) rsp_valid_in = 1'b1;
      else if (!rsp_stall)      rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ring memory: write from the last stage, two reads into stage 1
   always_ff @(posedge clock) begin
      if (s5_go) ring_mem[s5_addr_ff] <= wr_data;
      if (s1_free) begin
         rd_a_ff <= ring_mem[back_addr];
         rd_b_ff <= ring_mem[pos_ff];
      end
   end

   // older plus newer, folded mod 2^31-1 (2^31 folds to 1)
   assign sum_raw  = {1'b0, rd_a_ff} + {1'b0, rd_b_ff};
   assign sum_fold = {1'b0, sum_raw[WORD_W-1:0]} + {{WORD_W{1'b0}}, sum_raw[WORD_W]};
   assign sum_mod  = (sum_fold >= {1'b0, MOD_VAL}) ? WORD_W'(sum_fold - {1'b0, MOD_VAL})
                                                   : sum_fold[WORD_W-1:0];

   // second fold of the product and final correction
   assign fold2    = {1'b0, s4_data_ff[WORD_W-1:0]} + {{WORD_W{1'b0}}, s4_data_ff[WORD_W]};
   assign prod_mod = (fold2 >= {1'b0, MOD_VAL}) ? WORD_W'(fold2 - {1'b0, MOD_VAL})
                                                : fold2[WORD_W-1:0];

   // negate mod 2^31-1
   assign draw_x  = (s5_data_ff == '0) ? '0 : MOD_VAL - s5_data_ff;
   assign wr_data = s5_load_ff ? s5_data_ff : draw_x;

   // stage payload registers
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_load_ff  <= (req_kind == KIND_LOAD);
         s1_addr_ff  <= (req_kind == KIND_LOAD) ? req_word_index : pos_ff;
         s1_value_ff <= req_word_value;
      end
      if (s2_free) begin
         s2_load_ff <= s1_load_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_data_ff <= s1_load_ff ? s1_value_ff : sum_mod;
      end
      if (s3_free) begin
         s3_load_ff <= s2_load_ff;
         s3_addr_ff <= s2_addr_ff;
         s3_data_ff <= s2_load_ff ? {{MULT_W{1'b0}}, s2_data_ff}
                                  : PROD_W'(s2_data_ff) * PROD_W'(MULT_MAG);
      end
      if (s4_free) begin
         s4_load_ff <= s3_load_ff;
         s4_addr_ff <= s3_addr_ff;
         s4_data_ff <= s3_load_ff ? {1'b0, s3_data_ff[WORD_W-1:0]}
                                  : {1'b0, s3_data_ff[WORD_W-1:0]}
                                    + (WORD_W+1)'(s3_data_ff[PROD_W-1:WORD_W]);
      end
      if (s5_free) begin
         s5_load_ff <= s4_load_ff;
         s5_addr_ff <= s4_addr_ff;
         s5_data_ff <= s4_load_ff ? s4_data_ff[WORD_W-1:0] : prod_mod;
      end
      if (s5_go && !s5_load_ff) rsp_value_ff <= draw_x;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // checks
   `LMRG_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= LAST_POS)
   `LMRG_ASSERT_IMP(a_wr_range, clock, reset, s5_go, s5_addr_ff <= LAST_POS)
   `LMRG_ASSERT_IMP(a_rsp_reduced, clock, reset, rsp_valid_ff, rsp_value_ff != MOD_VAL)
   `LMRG_ASSERT_NXT(a_draw_to_rsp, clock, reset, s5_go && !s5_load_ff, rsp_valid_ff)

endmodule

>>> tb/lagged_mrg_random_generator_tb.sv
// self-checking testbench for the dx-1597-2-7 lagged mrg random generator
// depends on lmrg_pkg and lagged_mrg_random_generator; predicts every draw in a small tracker
// class and drives seed loads, position sets and draw bursts under varying idle patterns
module lagged_mrg_random_generator_tb;
   import lmrg_pkg::*;

   localparam int LONG_LAG  = 1597;
   localparam int SHORT_LAG = 7;
   localparam int IDX_W     = $clog2(LONG_LAG);
   localparam int IDX_MAX   = (1 << IDX_W) - 1;
   localparam int ITEM_GOAL = 650;
   localparam int PHASES    = 4;

   // the fourth request code, which the block ignores
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind       = KIND_LOAD;
   logic [IDX_W-1:0]  req_word_index = '0;
   logic [WORD_W-1:0] req_word_value = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [WORD_W-1:0] rsp_random_value;

   // idle percentages of the current phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // stimulus-side view of which slots hold a word and where the position is
   bit          slot_loaded [LONG_LAG];
   int unsigned gen_pos    = 0;
   int unsigned item_count = 0;

   // tracks the ring and position, and holds the draw values still to come out
   class dx_draw_tracker;
      logic [WORD_W-1:0] ring [LONG_LAG];
      int unsigned       position = 0;
      logic [WORD_W-1:0] pending_values [$];
      int unsigned       mismatches = 0;

      // one step of the recurrence at the current position
      function logic [WORD_W-1:0] next_value();
         int unsigned       back;
         longint unsigned   total;
         longint unsigned   scaled;
         logic [WORD_W-1:0] x;
         back   = (position >= SHORT_LAG) ? position - SHORT_LAG
                                          : position + LONG_LAG - SHORT_LAG;
         total  = (64'(ring[back]) + 64'(ring[position])) % 64'(MOD_VAL);
         scaled = (total * 64'(MULT_MAG)) % 64'(MOD_VAL);
         x      = (scaled == 0) ? '0 : MOD_VAL - WORD_W'(scaled);
         ring[position] = x;
         position = (position + 1 == LONG_LAG) ? 0 : position + 1;
         return x;
      endfunction

      function void apply_beat(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                               logic [WORD_W-1:0] value);
         case (kind)
            KIND_LOAD: begin
               if (idx < LONG_LAG) ring[idx] = value;
            end
            KIND_DRAW: begin
               pending_values.push_back(next_value());
            end
            KIND_SETPOS: begin
               if (idx < LONG_LAG) position = idx;
            end
            default: ;
         endcase
      endfunction

      function void compare_value(logic [WORD_W-1:0] actual);
         logic [WORD_W-1:0] wanted;
         if (pending_values.size() == 0) begin
            $error("random_value: expected none, actual %h", actual);
            mismatches++;
         end else begin
            wanted = pending_values.pop_front();
            if (actual !== wanted) begin
               $error("random_value: expected %h, actual %h", wanted, actual);
               mismatches++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_values.size();
      endfunction
   endclass

   dx_draw_tracker draws = new;

   lagged_mrg_random_generator #(
      .LONG_LAG  (LONG_LAG),
      .SHORT_LAG (SHORT_LAG)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_word_index   (req_word_index),
      .req_word_value   (req_word_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request beats go into the tracker
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         draws.apply_beat(req_kind, req_word_index, req_word_value);
   end

   // result beats are checked, then the next stall is drawn
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) draws.compare_value(rsp_random_value);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // seed words lean toward zero, the modulus and its neighbor
   function automatic logic [WORD_W-1:0] seed_word();
      case ($urandom_range(9))
         0: return '0;
         1: return MOD_VAL;
         2: return MOD_VAL - WORD_W'(1);
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // one request beat, with random idle cycles ahead of it
   task automatic send_item(input logic [KIND_W-1:0] kind, input int unsigned idx,
                            input logic [WORD_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_word_index <= IDX_W'(idx);
      req_word_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // follow what the beat did to ring and position
      case (kind)
         KIND_LOAD: begin
            if (idx < LONG_LAG) begin
               slot_loaded[idx] = 1'b1;
               item_count++;
            end
         end
         KIND_DRAW: begin
            gen_pos = (gen_pos + 1) % LONG_LAG;
            item_count++;
         end
         KIND_SETPOS: begin
            if (idx < LONG_LAG) begin
               gen_pos = idx;
               item_count++;
            end
         end
         default: ;
      endcase
   endtask

   // beats the block has to ignore
   task automatic send_noise();
      case ($urandom_range(2))
         0: send_item(KIND_UNUSED, $urandom_range(IDX_MAX), WORD_W'($urandom));
         1: send_item(KIND_LOAD, $urandom_range(IDX_MAX, LONG_LAG), WORD_W'($urandom));
         default: send_item(KIND_SETPOS, $urandom_range(IDX_MAX, LONG_LAG),
                            WORD_W'($urandom));
      endcase
   endtask

   // seed the slots a run of draws reads, place the position, then draw
   task automatic run_burst();
      int unsigned start;
      int unsigned runs;
      int unsigned slot;
      case ($urandom_range(3))
         0: start = gen_pos;
         1: start = $urandom_range(1) ? 0 : LONG_LAG - 1 - $urandom_range(SHORT_LAG);
         default: start = $urandom_range(LONG_LAG - 1);
      endcase
      runs = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
      for (int k = 0; k < runs + SHORT_LAG; k++) begin
         slot = (start + LONG_LAG - SHORT_LAG + k) % LONG_LAG;
         if (!slot_loaded[slot] || $urandom_range(7) == 0)
            send_item(KIND_LOAD, slot, seed_word());
         if ($urandom_range(19) == 0) send_noise();
      end
      if (start != gen_pos || $urandom_range(3) == 0)
         send_item(KIND_SETPOS, start, WORD_W'($urandom));
      for (int k = 0; k < runs; k++) begin
         send_item(KIND_DRAW, $urandom_range(IDX_MAX), WORD_W'($urandom));
         if ($urandom_range(19) == 0) send_noise();
      end
   endtask

   initial begin
      int unsigned base;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored kinds and slots, modulus seeds, wrap of the position
      send_item(KIND_UNUSED, IDX_MAX, MOD_VAL);
      send_item(KIND_LOAD, IDX_MAX, MOD_VAL);
      send_item(KIND_LOAD, LONG_LAG, 31'h1234_5678);
      send_item(KIND_LOAD, LONG_LAG - SHORT_LAG, MOD_VAL);
      send_item(KIND_LOAD, 0, '0);
      send_item(KIND_DRAW, 0, '0);
      send_item(KIND_LOAD, LONG_LAG - SHORT_LAG + 1, MOD_VAL - WORD_W'(1));
      send_item(KIND_LOAD, 1, MOD_VAL - WORD_W'(1));
      send_item(KIND_DRAW, IDX_MAX, MOD_VAL);
      send_item(KIND_SETPOS, IDX_MAX, '0);
      send_item(KIND_LOAD, LONG_LAG - SHORT_LAG + 2, 31'h0000_0001);
      send_item(KIND_LOAD, 2, 31'h4000_0000);
      send_item(KIND_DRAW, 0, '0);
      send_item(KIND_SETPOS, LONG_LAG - 1, '0);
      send_item(KIND_LOAD, LONG_LAG - 1 - SHORT_LAG, 31'h2AAA_AAAA);
      send_item(KIND_LOAD, LONG_LAG - 1, 31'h5555_5555);
      send_item(KIND_DRAW, 0, '0);
      send_item(KIND_DRAW, 0, '0);
      send_item(KIND_DRAW, 0, '0);
      send_item(KIND_SETPOS, LONG_LAG, '0);
      send_item(KIND_DRAW, 0, '0);
      send_item(KIND_SETPOS, 0, MOD_VAL);
      send_item(KIND_LOAD, 0, MOD_VAL - WORD_W'(1));
      send_item(KIND_DRAW, 0, '0);
      send_item(KIND_DRAW, 0, '0);

      // random bursts under each idle pattern, draining between phases
      base = item_count;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 70;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 70;
            end
            default: begin
               send_idle_pct  = 9;
               recv_stall_pct = 9;
            end
         endcase
         while (item_count < base + (phase + 1) * ITEM_GOAL / PHASES) run_burst();
         req_valid <= 1'b0;
         do @(posedge clock); while (draws.outstanding() != 0);
      end

      // drained; let any stray result show up
      recv_stall_pct = 0;
      repeat (16) @(posedge clock);
      if (draws.mismatches == 0 && draws.outstanding() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/lmrg_pkg.sv
rtl/lagged_mrg_random_generator.sv
tb/lagged_mrg_random_generator_tb.sv
